// ----- hw/rtl/jacobi_stencil_sweep_top_defines.svh -----
// ----------------------------------------------------------------------------
// jacobi stencil sweep assertion macros
// shared concurrent check wrappers, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef JACOBI_STENCIL_SWEEP_TOP_DEFINES_SVH
`define JACOBI_STENCIL_SWEEP_TOP_DEFINES_SVH

// property holds at every edge outside reset
`define JSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent holds in the cycle after the antecedent
`define JSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/jss_pkg.sv -----
// ----------------------------------------------------------------------------
// jss_pkg
// shared types and constants of the jacobi stencil sweep block
// ----------------------------------------------------------------------------
package jss_pkg;

    // field widths on the ports
    localparam int SAMPLE_W   = 23;
    localparam int ROW_W      = 16;
    localparam int OUT_COL_W  = 9;
    localparam int GW_W       = 10;
    localparam int GH_W       = 16;
    localparam int TOL_W      = 23;
    localparam int CFG_DATA_W = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 72;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // register indexes
    localparam cfg_idx_t CFG_GRID_WIDTH  = 2'd0;
    localparam cfg_idx_t CFG_GRID_HEIGHT = 2'd1;
    localparam cfg_idx_t CFG_TOLERANCE   = 2'd2;

    // register reset values
    localparam logic [GW_W-1:0]  GRID_WIDTH_RST  = 10'd500;
    localparam logic [GH_W-1:0]  GRID_HEIGHT_RST = 16'd500;
    localparam logic [TOL_W-1:0] TOLERANCE_RST   = 23'd66;

    typedef struct packed {
        logic [GW_W-1:0]  grid_width;
        logic [GH_W-1:0]  grid_height;
        logic [TOL_W-1:0] tolerance;
    } cfg_t;

    // position info of the item at the head of the scan
    typedef struct packed {
        logic [ROW_W-1:0] out_row;
        logic             emit;
        logic             boundary;
        logic             done;
    } pos_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  new_value;
        logic [ROW_W-1:0]     out_row;
        logic [OUT_COL_W-1:0] out_col;
        logic                 sweep_done;
        logic [SAMPLE_W-1:0]  max_change;
        logic                 converged;
    } res_t;

endpackage

// ----- hw/rtl/jacobi_stencil_sweep_top.sv -----
// ----------------------------------------------------------------------------
// jacobi_stencil_sweep_top
// streaming five-point jacobi sweep over a raster-ordered grid
// ----------------------------------------------------------------------------
// Takes one grid sample per clock unless the output stalls, a rate set by
// the single pair memory (previous two rows of one column per word) whose
// read for the next column is issued with each transfer. Via the stage-1
// and output registers it returns for the sample (r,c) the updated value
// of cell (r-1,c) for rows 1 to height-2; rows 0 and 1 only fill the line
// stores. The last result of a sweep carries tlast, the largest change of
// the sweep and the converged flag. Line stores have no reset and need no
// clearing pass; the first two rows of each sweep overwrite them.
module jacobi_stencil_sweep_top #(
    parameter int MAX_WIDTH  = 512,
    parameter int VALUE_BITS = 23
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  jss_pkg::cfg_idx_t              cfg_index,
    input  logic [jss_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // sample
    input  logic [jss_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // new_value, out_row, out_col, max_change
    output logic [jss_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast,
    // converged
    output logic                           m_tuser
);

    import jss_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    cfg_t                    cfg;
    pos_t                    pos;
    res_t                    res;
    logic [COL_W-1:0]        col;
    logic [COL_W-1:0]        rd_addr;
    logic                    accept;
    logic                    ram_we;
    logic [COL_W-1:0]        ram_waddr;
    logic [2*VALUE_BITS-1:0] ram_wdata;
    logic [2*VALUE_BITS-1:0] rd_data;
    logic [VALUE_BITS-1:0]   sample;

    assign sample = VALUE_BITS'(s_tdata[SAMPLE_W-1:0]);

    jss_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    jss_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .accept  (accept),
        .pos     (pos),
        .col     (col),
        .rd_addr (rd_addr)
    );

    // word layout: older row in the upper half, recent row in the lower
    jss_ram #(
        .WIDTH (2 * VALUE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    jss_stencil #(
        .MAX_WIDTH  (MAX_WIDTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_stencil (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .sample    (sample),
        .pos       (pos),
        .col       (col),
        .rd_addr   (rd_addr),
        .tolerance (cfg.tolerance),
        .rd_data   (rd_data),
        .accept    (accept),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .res       (res)
    );

    assign m_tdata = {1'b0, res.max_change, res.out_col, res.out_row, res.new_value};
    assign m_tlast = res.sweep_done;
    assign m_tuser = res.converged;

endmodule

// ----- hw/rtl/jss_ram.sv -----
// ----------------------------------------------------------------------------
// jss_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module jss_ram #(
    parameter int WIDTH = 46,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/jss_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// jss_cfg_regs
// configuration register file: grid width, grid height, tolerance
// ----------------------------------------------------------------------------
module jss_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  jss_pkg::cfg_idx_t             cfg_index,
    input  logic [jss_pkg::CFG_DATA_W-1:0] cfg_data,
    output jss_pkg::cfg_t                 cfg
);

    import jss_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:  cfg_next.grid_width  = cfg_data[GW_W-1:0];
                CFG_GRID_HEIGHT: cfg_next.grid_height = cfg_data[GH_W-1:0];
                CFG_TOLERANCE:   cfg_next.tolerance   = cfg_data[TOL_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_width  <= GRID_WIDTH_RST;
            cfg_reg.grid_height <= GRID_HEIGHT_RST;
            cfg_reg.tolerance   <= TOLERANCE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/jss_scan.sv -----
// ----------------------------------------------------------------------------
// jss_scan
// raster position counters and line store read address for the next column
// ----------------------------------------------------------------------------
module jss_scan #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  jss_pkg::cfg_t                cfg,
    input  logic                         accept,
    output jss_pkg::pos_t                pos,
    output logic [$clog2(MAX_WIDTH)-1:0] col,
    output logic [$clog2(MAX_WIDTH)-1:0] rd_addr
);

    import jss_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WCMP  = (COL_W + 1 > GW_W) ? COL_W + 1 : GW_W;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [WCMP-1:0]  gw;
    logic [WCMP-1:0]  w_use;
    logic [WCMP-1:0]  w_last;
    logic [GH_W-1:0]  h_use;
    logic [GH_W-1:0]  h_last;
    logic             last_col;
    logic             last_row;

    always_comb
    begin
        gw = WCMP'(cfg.grid_width);
        priority if (gw < WCMP'(3))
        begin
            w_use = WCMP'(3);
        end
        else if (gw > WCMP'(MAX_WIDTH))
        begin
            w_use = WCMP'(MAX_WIDTH);
        end
        else
        begin
            w_use = gw;
        end
        w_last = w_use - WCMP'(1);
        h_use  = (cfg.grid_height < GH_W'(3)) ? GH_W'(3) : cfg.grid_height;
        h_last = h_use - GH_W'(1);

        // a column at or past the last one ends the row
        last_col = (WCMP'(col_reg) >= w_last);
        last_row = (row_reg >= h_last);

        // the last column fetches column 0 ahead of the next row
        col_next = last_col ? '0 : col_reg + COL_W'(1);
        row_next = row_reg;
        if (last_col)
        begin
            row_next = last_row ? '0 : row_reg + ROW_W'(1);
        end

        pos.out_row  = row_reg - ROW_W'(1);
        pos.emit     = (row_reg >= ROW_W'(2));
        pos.boundary = (col_reg == '0) || last_col;
        pos.done     = last_col && last_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col     = col_reg;
    assign rd_addr = col_next;

endmodule

// ----- hw/rtl/jss_stencil.sv -----
// ----------------------------------------------------------------------------
// jss_stencil
// five-point update stage, running max of change, line store write back and
// output register
// ----------------------------------------------------------------------------
`include "jacobi_stencil_sweep_top_defines.svh"

module jss_stencil #(
    parameter int MAX_WIDTH  = 512,
    parameter int VALUE_BITS = 23
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [VALUE_BITS-1:0]        sample,
    input  jss_pkg::pos_t                pos,
    input  logic [$clog2(MAX_WIDTH)-1:0] col,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  logic [jss_pkg::TOL_W-1:0]    tolerance,
    input  logic [2*VALUE_BITS-1:0]      rd_data,
    output logic                         accept,
    output logic                         ram_we,
    output logic [$clog2(MAX_WIDTH)-1:0] ram_waddr,
    output logic [2*VALUE_BITS-1:0]      ram_wdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output jss_pkg::res_t                res
);

    import jss_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int SUM_W = VALUE_BITS + 2;
    localparam int CMP_W = (VALUE_BITS > TOL_W) ? VALUE_BITS : TOL_W;

    logic                  s1_valid_reg;
    pos_t                  s1_pos_reg;
    logic [COL_W-1:0]      s1_col_reg;
    logic [VALUE_BITS-1:0] s1_sample_reg;
    logic [VALUE_BITS-1:0] north_reg;
    logic [VALUE_BITS-1:0] centre_reg;
    logic [VALUE_BITS-1:0] west_reg;
    logic [VALUE_BITS-1:0] max_reg;
    logic [VALUE_BITS-1:0] max_next;
    logic                  out_valid_reg;
    res_t                  out_reg;
    res_t                  out_next;

    logic                  s1_adv;
    logic                  s1_emit;
    logic                  out_free;
    logic [VALUE_BITS-1:0] east;
    logic [SUM_W-1:0]      sum;
    logic [VALUE_BITS-1:0] avg;
    logic [VALUE_BITS-1:0] nv;
    logic [VALUE_BITS-1:0] diff;
    logic [VALUE_BITS-1:0] max_upd;

    assign s1_emit  = s1_valid_reg && s1_pos_reg.emit;
    assign out_free = !out_valid_reg || m_tready;
    assign s1_adv   = !s1_emit || out_free;
    assign s_tready = s1_adv;
    assign accept   = s_tvalid && s_tready;

    // the read issued with this item returns the next column: east here,
    // north and centre for the item that follows
    always_comb
    begin
        east = rd_data[VALUE_BITS-1:0];
        sum  = SUM_W'(s1_sample_reg) + SUM_W'(north_reg)
             + SUM_W'(west_reg) + SUM_W'(east);
        avg  = sum[SUM_W-1:2];
        nv   = s1_pos_reg.boundary ? centre_reg : avg;
        diff = (avg >= centre_reg) ? avg - centre_reg : centre_reg - avg;
        max_upd = (!s1_pos_reg.boundary && diff > max_reg) ? diff : max_reg;
        max_next = s1_pos_reg.done ? '0 : max_upd;

        out_next.new_value  = SAMPLE_W'(nv);
        out_next.out_row    = s1_pos_reg.out_row;
        out_next.out_col    = OUT_COL_W'(s1_col_reg);
        out_next.sweep_done = s1_pos_reg.done;
        out_next.max_change = s1_pos_reg.done ? SAMPLE_W'(max_upd) : '0;
        out_next.converged  = s1_pos_reg.done
                              && (CMP_W'(max_upd) < CMP_W'(tolerance));
    end

    assign ram_we    = s1_valid_reg && s1_adv;
    assign ram_waddr = s1_col_reg;
    assign ram_wdata = {centre_reg, s1_sample_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_reg       <= '0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= accept;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_emit;
            end
            if (s1_emit && out_free)
            begin
                max_reg <= max_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg    <= pos;
            s1_col_reg    <= col;
            s1_sample_reg <= sample;
            north_reg     <= rd_data[2*VALUE_BITS-1:VALUE_BITS];
            centre_reg    <= rd_data[VALUE_BITS-1:0];
            west_reg      <= centre_reg;
        end
        if (s1_emit && out_free)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign res      = out_reg;

    `JSS_ASSERT(a_no_rw_collision, (ram_we && accept) |-> (ram_waddr != rd_addr), "line store read and write hit the same column")
    `JSS_ASSERT_NEXT(a_max_cleared, s1_emit && out_free && s1_pos_reg.done, max_reg == '0, "running max not cleared after sweep end")
    `JSS_ASSERT(a_max_only_on_done, (out_valid_reg && !out_reg.sweep_done) |-> (out_reg.max_change == '0 && !out_reg.converged), "sweep summary set on a result that is not the last")

endmodule

// ----- verif/jacobi_stencil_sweep_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jacobi_stencil_sweep_top_test
// self-checking bench for the streaming jacobi sweep: a short directed table
// (extremes, saturated sizes, a mid-sweep resize) followed by random sweeps
// over four idle/stall phases; every output transfer is compared field by
// field with a cycle-free model of the line stores and the running maximum
// ----------------------------------------------------------------------------
module jacobi_stencil_sweep_top_test;
    import jss_pkg::*;

    localparam int MAX_W        = 512;
    localparam int VAL_W        = 23;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 490;
    localparam logic [VAL_W-1:0] VAL_MAX = 23'h7FFFFF;
    localparam cfg_idx_t CFG_UNMAPPED = 2'd3;

    typedef enum logic {TAB_CFG, TAB_SAMPLE} tab_kind_e;
    typedef enum int {DATA_NOISE, DATA_SMOOTH, DATA_EXTREME} data_mode_e;

    typedef struct {
        logic [VAL_W-1:0] value;
        bit               typed;
        bit               typed_has;
        res_t             typed_res;
    } grid_item_t;

    typedef struct {
        tab_kind_e  kind;
        cfg_idx_t   index;
        grid_item_t item;
    } tab_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    cfg_idx_t              cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    // model state: the two rows above the current one and the sweep counters
    logic [VAL_W-1:0] two_up_row [MAX_W];
    logic [VAL_W-1:0] one_up_row [MAX_W];
    logic [VAL_W-1:0] center_reg;
    logic [VAL_W-1:0] peak_change;
    int unsigned      cur_row;
    int unsigned      cur_col;
    logic [GW_W-1:0]  width_reg;
    logic [GH_W-1:0]  height_reg;
    logic [TOL_W-1:0] tol_reg;

    grid_item_t  pending_samples[$];
    res_t        expected_cells[$];
    tab_row_t    directed_rows[$];
    int          fail_count   = 0;
    int          idle_pct     = 0;
    int          stall_pct    = 0;
    int unsigned random_items = 0;
    int unsigned cycle_count  = 0;

    jacobi_stencil_sweep_top #(
        .MAX_WIDTH  (MAX_W),
        .VALUE_BITS (VAL_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned width_in_force();
        int unsigned w;
        w = width_reg;
        if (w < 3) w = 3;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int unsigned height_in_force();
        int unsigned h;
        h = height_reg;
        if (h < 3) h = 3;
        return h;
    endfunction

    function automatic int unsigned samples_to_sweep_end();
        int unsigned w;
        int unsigned h;
        int unsigned in_row;
        int unsigned rows_after;
        w = width_in_force();
        h = height_in_force();
        in_row = (cur_col >= w - 1) ? 1 : w - cur_col;
        rows_after = (cur_row >= h - 1) ? 0 : h - 1 - cur_row;
        return in_row + rows_after * w;
    endfunction

    // one sample in, at most one updated cell of the row above out
    task automatic update_cell(input logic [VAL_W-1:0] south, output bit has_res,
                               output res_t res);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        logic [VAL_W-1:0] north;
        logic [VAL_W-1:0] centre;
        logic [VAL_W-1:0] east;
        logic [VAL_W-1:0] nv;
        logic [VAL_W-1:0] diff;
        logic [VAL_W+1:0] total;
        bit               last_col;
        bit               last_row;
        bit               done;
        w = width_in_force();
        h = height_in_force();
        c = cur_col;
        r = cur_row;
        last_col = (c >= w - 1);
        last_row = (r >= h - 1);
        done = last_col && last_row;
        if (c >= MAX_W) c = MAX_W - 1;
        north = two_up_row[c];
        centre = one_up_row[c];
        east = (c + 1 < MAX_W) ? one_up_row[c + 1] : '0;
        has_res = (r >= 2);
        res = '0;
        if (has_res)
        begin
            if (c == 0 || last_col)
                nv = centre;
            else
            begin
                total = north + south + center_reg + east;
                nv = total[VAL_W+1:2];
                diff = (nv >= centre) ? nv - centre : centre - nv;
                if (diff > peak_change) peak_change = diff;
            end
            res.new_value  = nv;
            res.out_row    = ROW_W'(r - 1);
            res.out_col    = OUT_COL_W'(c);
            res.sweep_done = done;
            res.max_change = done ? peak_change : '0;
            res.converged  = done && (peak_change < tol_reg);
        end
        center_reg = centre;
        two_up_row[c] = centre;
        one_up_row[c] = south;
        if (last_col)
        begin
            cur_col = 0;
            if (last_row)
            begin
                cur_row = 0;
                peak_change = '0;
            end
            else
                cur_row = r + 1;
        end
        else
            cur_col = c + 1;
    endtask

    task automatic check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // sender: holds an item until its transfer, then predicts it
    always @(posedge clk)
    begin : sender
        bit   has_res;
        res_t cell_res;
        if (s_tvalid && s_tready)
        begin
            update_cell(pending_samples[0].value, has_res, cell_res);
            if (pending_samples[0].typed)
            begin
                has_res = pending_samples[0].typed_has;
                cell_res = pending_samples[0].typed_res;
            end
            if (has_res) expected_cells.push_back(cell_res);
            pending_samples.delete(0);
        end
        if (!(s_tvalid && !s_tready))
        begin
            if (pending_samples.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= S_TDATA_W'(pending_samples[0].value);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin : monitor
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.new_value  = m_tdata[22:0];
            got.out_row    = m_tdata[38:23];
            got.out_col    = m_tdata[47:39];
            got.max_change = m_tdata[70:48];
            got.sweep_done = m_tlast;
            got.converged  = m_tuser;
            if (expected_cells.size() == 0)
            begin
                $error("result transfer with nothing expected: row %0d col %0d",
                       got.out_row, got.out_col);
                fail_count++;
            end
            else
            begin
                want = expected_cells.pop_front();
                check_field("new_value", want.new_value, got.new_value);
                check_field("out_row", want.out_row, got.out_row);
                check_field("out_col", want.out_col, got.out_col);
                check_field("sweep_done", want.sweep_done, got.sweep_done);
                check_field("max_change", want.max_change, got.max_change);
                check_field("converged", want.converged, got.converged);
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic wait_idle();
        do @(negedge clk);
        while (pending_samples.size() != 0 || s_tvalid || expected_cells.size() != 0);
        // a row-0 or row-1 sample leaves no result but may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_GRID_WIDTH:  width_reg  = value[GW_W-1:0];
            CFG_GRID_HEIGHT: height_reg = value[GH_W-1:0];
            CFG_TOLERANCE:   tol_reg    = value[TOL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic add_sample_row(logic [VAL_W-1:0] value, bit typed, bit has, res_t res);
        tab_row_t row;
        row.kind = TAB_SAMPLE;
        row.index = '0;
        row.item.value = value;
        row.item.typed = typed;
        row.item.typed_has = has;
        row.item.typed_res = res;
        directed_rows.push_back(row);
    endtask

    task automatic add_write_row(cfg_idx_t idx, logic [VAL_W-1:0] value);
        tab_row_t row;
        row.kind = TAB_CFG;
        row.index = idx;
        row.item.value = value;
        row.item.typed = 1'b0;
        row.item.typed_has = 1'b0;
        row.item.typed_res = '0;
        directed_rows.push_back(row);
    endtask

    task automatic send_grid(int unsigned n, data_mode_e mode, logic [VAL_W-1:0] base);
        grid_item_t item;
        item.typed = 1'b0;
        item.typed_has = 1'b0;
        item.typed_res = '0;
        @(negedge clk);
        repeat (n)
        begin
            case (mode)
                DATA_SMOOTH: item.value = base + VAL_W'($urandom_range(0, 63));
                DATA_EXTREME:
                    case ($urandom_range(0, 3))
                        0: item.value = '0;
                        1: item.value = VAL_MAX;
                        2: item.value = 23'h400000;
                        default: item.value = 23'h3FFFFF;
                    endcase
                default: item.value = VAL_W'($urandom());
            endcase
            pending_samples.push_back(item);
        end
        random_items += n;
    endtask

    function automatic logic [GW_W-1:0] pick_width(bit grow_ok);
        // past row 0 the width only shrinks, so no unwritten store entry is read
        if (!grow_ok) return GW_W'($urandom_range(0, width_in_force()));
        case ($urandom_range(0, 7))
            0: return GW_W'($urandom_range(0, 2));
            1: return GW_W'($urandom_range(11, 40));
            default: return GW_W'($urandom_range(3, 10));
        endcase
    endfunction

    function automatic logic [GH_W-1:0] pick_height();
        if ($urandom_range(0, 7) == 0) return GH_W'($urandom_range(0, 2));
        return GH_W'($urandom_range(3, 6));
    endfunction

    function automatic logic [TOL_W-1:0] pick_tol();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return VAL_MAX;
            2: return TOL_W'($urandom());
            default: return TOL_W'($urandom_range(0, 128));
        endcase
    endfunction

    task automatic random_sweep(bit big);
        data_mode_e       mode;
        logic [VAL_W-1:0] base;
        int unsigned      left;
        wait_idle();
        if (big)
        begin
            // both sizes saturate: 512 columns, 3 rows
            write_reg(CFG_GRID_WIDTH, {13'($urandom()), 10'd1023});
            write_reg(CFG_GRID_HEIGHT, {7'($urandom()), 16'd2});
        end
        else
        begin
            write_reg(CFG_GRID_WIDTH, {13'($urandom()), pick_width(cur_row == 0)});
            write_reg(CFG_GRID_HEIGHT, {7'($urandom()), pick_height()});
        end
        if ($urandom_range(0, 3) != 0) write_reg(CFG_TOLERANCE, pick_tol());
        mode = data_mode_e'($urandom_range(0, 2));
        base = VAL_W'($urandom_range(0, 23'h7FFFBF));
        if (!big && $urandom_range(0, 3) == 0)
        begin
            left = samples_to_sweep_end();
            send_grid($urandom_range(1, left - 1), mode, base);
            wait_idle();
            if ($urandom_range(0, 2) == 0)
            begin
                // tallest grid for a few rows, then cut the sweep short
                write_reg(CFG_GRID_HEIGHT, {7'($urandom()), 16'hFFFF});
                send_grid(2 * width_in_force() + $urandom_range(0, width_in_force()),
                          mode, base);
                wait_idle();
                write_reg(CFG_GRID_HEIGHT,
                          {7'($urandom()), 16'($urandom_range(0, cur_row + 2))});
            end
            else
            begin
                if ($urandom_range(0, 1))
                    write_reg(CFG_GRID_WIDTH, {13'($urandom()), pick_width(cur_row == 0)});
                if ($urandom_range(0, 1))
                    write_reg(CFG_GRID_HEIGHT, {7'($urandom()), pick_height()});
                if ($urandom_range(0, 1)) write_reg(CFG_TOLERANCE, pick_tol());
            end
        end
        send_grid(samples_to_sweep_end(), mode, base);
    endtask

    initial
    begin : main
        int          phase;
        int unsigned phase_start;
        for (int i = 0; i < MAX_W; i++)
        begin
            two_up_row[i] = '0;
            one_up_row[i] = '0;
        end
        center_reg  = '0;
        peak_change = '0;
        cur_row     = 0;
        cur_col     = 0;
        width_reg   = GRID_WIDTH_RST;
        height_reg  = GRID_HEIGHT_RST;
        tol_reg     = TOLERANCE_RST;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // first row starts at the reset width, then the grid narrows to 3
        add_sample_row(VAL_MAX, 1'b1, 1'b0, '0);
        add_sample_row(VAL_MAX, 1'b1, 1'b0, '0);
        add_write_row(CFG_GRID_WIDTH, 23'd3);
        add_write_row(CFG_GRID_HEIGHT, 23'd3);
        add_write_row(CFG_TOLERANCE, VAL_MAX);
        add_sample_row(VAL_MAX, 1'b1, 1'b0, '0);
        repeat (3) add_sample_row('0, 1'b1, 1'b0, '0);
        add_sample_row(VAL_MAX, 1'b1, 1'b1, res_t'{23'd0, 16'd1, 9'd0, 1'b0, 23'd0, 1'b0});
        add_sample_row(VAL_MAX, 1'b1, 1'b1,
                       res_t'{23'h3FFFFF, 16'd1, 9'd1, 1'b0, 23'd0, 1'b0});
        add_sample_row(VAL_MAX, 1'b1, 1'b1,
                       res_t'{23'd0, 16'd1, 9'd2, 1'b1, 23'h3FFFFF, 1'b1});
        // sizes below the minimum saturate to 3, zero tolerance never converges
        add_write_row(CFG_GRID_WIDTH, 23'd1);
        add_write_row(CFG_GRID_HEIGHT, 23'd0);
        add_write_row(CFG_TOLERANCE, 23'd0);
        repeat (6) add_sample_row(VAL_MAX, 1'b1, 1'b0, '0);
        add_sample_row(VAL_MAX, 1'b1, 1'b1, res_t'{VAL_MAX, 16'd1, 9'd0, 1'b0, 23'd0, 1'b0});
        add_sample_row(VAL_MAX, 1'b1, 1'b1, res_t'{VAL_MAX, 16'd1, 9'd1, 1'b0, 23'd0, 1'b0});
        add_sample_row(VAL_MAX, 1'b1, 1'b1, res_t'{VAL_MAX, 16'd1, 9'd2, 1'b1, 23'd0, 1'b0});
        add_sample_row(23'h555555, 1'b0, 1'b0, '0);
        add_sample_row(23'h2AAAAA, 1'b0, 1'b0, '0);
        add_sample_row(23'h000001, 1'b0, 1'b0, '0);
        add_sample_row(23'h7FFFFE, 1'b0, 1'b0, '0);
        add_sample_row(23'h400000, 1'b0, 1'b0, '0);
        add_sample_row(23'h3FFFFF, 1'b0, 1'b0, '0);
        add_sample_row(23'h000001, 1'b0, 1'b0, '0);
        add_sample_row(VAL_MAX, 1'b0, 1'b0, '0);
        add_sample_row(23'h123456, 1'b0, 1'b0, '0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == TAB_CFG)
            begin
                wait_idle();
                write_reg(directed_rows[i].index, directed_rows[i].item.value);
            end
            else
            begin
                @(negedge clk);
                pending_samples.push_back(directed_rows[i].item);
            end
        end

        for (phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom()));
            @(negedge clk);
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 77;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 77;
                end
                default:
                begin
                    idle_pct = 36;
                    stall_pct = 36;
                end
            endcase
            if (phase == 0) random_sweep(1'b1);
            phase_start = random_items;
            while (random_items - phase_start < PHASE_ITEMS) random_sweep(1'b0);
        end

        wait_idle();
        if (fail_count == 0 && expected_cells.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
